>>> hw/rtl/sddq_pkg.sv
// Shared constants, beat types and controller/datapath interface types.
`default_nettype none
package sddq_pkg;

  localparam int unsigned NUM_STICKS = 2;
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned DZ_W       = 15;
  localparam int unsigned EN_W       = 8;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned MAG_W      = 8;
  localparam int unsigned NUM_DIRS   = 4;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned NUM_W      = AXIS_W + MAG_W;
  localparam int unsigned DIV_STEPS  = MAG_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  localparam logic [DZ_W-1:0]  DZ_RESET        = DZ_W'(8000);
  localparam logic [EN_W-1:0]  EN_RESET        = '1;
  localparam logic [DZ_W-1:0]  AXIS_FULL_SCALE = DZ_W'(32767);
  localparam logic [MAG_W-1:0] MAG_SPAN        = MAG_W'(254);
  localparam logic [MAG_W-1:0] MAG_MAX         = '1;

  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_ENABLE = 1'b1;

  typedef struct packed {
    logic                     stick;
    logic                     axis_is_y;
    logic signed [AXIS_W-1:0] position;
    logic signed [AXIS_W-1:0] other_position;
  } in_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0] direction_slot;
    logic              changed;
    logic [MAG_W-1:0]  magnitude;
    logic              last;
  } out_beat_t;

  typedef enum logic [1:0] {
    MUL_POS = 2'd0,
    MUL_OTH = 2'd1,
    MUL_DZ  = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic             load_in;
    logic             mul_en;
    mul_sel_t         mul_sel;
    logic             acc_load;
    logic             acc_add;
    logic             dz2_load;
    logic             div_init;
    logic             div_step;
    logic             out_load;
    logic [DIR_W-1:0] dir;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic [NUM_DIRS-1:0] dir_en;
    logic                in_range;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/sddq_dp.sv
// Datapath: config registers, squares, range test, serial divider, status flags, result register.
`default_nettype none
module sddq_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [sddq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sddq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire sddq_pkg::in_beat_t                 in_data,
  input  wire sddq_pkg::dp_cmd_t                  cmd,
  output sddq_pkg::dp_stat_t                      stat,
  output sddq_pkg::out_beat_t                     out_data
);

  logic [sddq_pkg::DZ_W-1:0]          dz_r;
  logic [sddq_pkg::EN_W-1:0]          en_r;
  logic                               stick_r;
  logic                               axy_r;
  logic signed [sddq_pkg::AXIS_W-1:0] pos_r;
  logic signed [sddq_pkg::AXIS_W-1:0] oth_r;
  logic [sddq_pkg::SQ_W-1:0]          prod_r;
  logic [sddq_pkg::SQ_W-1:0]          acc_r;
  logic [sddq_pkg::SQ_W-1:0]          dz2_r;
  logic [sddq_pkg::NUM_W-1:0]         rem_r;
  logic [sddq_pkg::NUM_W-1:0]         dsh_r;
  logic [sddq_pkg::MAG_W-1:0]         q_r;
  logic                               sat_r;
  logic [(1 << sddq_pkg::SLOT_W)-1:0] flags_r;
  sddq_pkg::out_beat_t                out_r;

  logic [sddq_pkg::AXIS_W-1:0]        abs_pos;
  logic [sddq_pkg::AXIS_W-1:0]        abs_oth;
  logic [sddq_pkg::AXIS_W-1:0]        mul_op;
  logic                               use_other;
  logic                               positive;
  logic signed [sddq_pkg::AXIS_W-1:0] axis_v;
  logic [sddq_pkg::AXIS_W-1:0]        a_mag;
  logic [sddq_pkg::AXIS_W-1:0]        o_mag;
  logic                               side_ok;
  logic                               in_range;
  logic [sddq_pkg::SLOT_W-1:0]        slot;
  logic [sddq_pkg::AXIS_W-1:0]        dz_ext;
  logic [sddq_pkg::AXIS_W-1:0]        diff;
  logic [sddq_pkg::NUM_W-1:0]         num;
  logic [sddq_pkg::DZ_W-1:0]          divisor;
  logic [sddq_pkg::NUM_W-1:0]         div_full;
  logic [sddq_pkg::MAG_W-1:0]         mag;
  logic [sddq_pkg::NUM_DIRS-1:0]      dir_en;

  assign abs_pos = pos_r[sddq_pkg::AXIS_W-1] ? sddq_pkg::AXIS_W'(-pos_r)
                                             : sddq_pkg::AXIS_W'(pos_r);
  assign abs_oth = oth_r[sddq_pkg::AXIS_W-1] ? sddq_pkg::AXIS_W'(-oth_r)
                                             : sddq_pkg::AXIS_W'(oth_r);
  assign dz_ext  = sddq_pkg::AXIS_W'(dz_r);

  always_comb begin
    case (cmd.mul_sel)
      sddq_pkg::MUL_POS: mul_op = abs_pos;
      sddq_pkg::MUL_OTH: mul_op = abs_oth;
      sddq_pkg::MUL_DZ:  mul_op = dz_ext;
      default:           mul_op = '0;
    endcase
  end

  // current direction
  assign use_other = cmd.dir[1];
  assign positive  = cmd.dir[0];
  assign axis_v    = use_other ? oth_r : pos_r;
  assign a_mag     = use_other ? abs_oth : abs_pos;
  assign o_mag     = use_other ? abs_pos : abs_oth;
  assign side_ok   = positive ? (!axis_v[sddq_pkg::AXIS_W-1] && (axis_v != '0))
                              : axis_v[sddq_pkg::AXIS_W-1];
  assign in_range  = side_ok && (a_mag >= (o_mag >> 1)) && (acc_r >= dz2_r);
  assign slot      = {stick_r, (use_other ? ~axy_r : axy_r), positive};

  assign diff     = (a_mag > dz_ext) ? (a_mag - dz_ext) : '0;
  assign num      = sddq_pkg::NUM_W'(diff) * sddq_pkg::NUM_W'(sddq_pkg::MAG_SPAN);
  assign divisor  = sddq_pkg::AXIS_FULL_SCALE - dz_r;
  assign div_full = sddq_pkg::NUM_W'({divisor, sddq_pkg::MAG_W'(0)});

  always_comb begin
    if (!in_range) begin
      mag = '0;
    end else if (sat_r || (q_r == sddq_pkg::MAG_MAX)) begin
      mag = sddq_pkg::MAG_MAX;
    end else begin
      mag = q_r + sddq_pkg::MAG_W'(1);
    end
  end

  always_comb begin
    logic [sddq_pkg::SLOT_W-1:0] s;
    logic                        stick_ok;
    stick_ok = (32'(stick_r) < sddq_pkg::NUM_STICKS);
    for (int d = 0; d < sddq_pkg::NUM_DIRS; d++) begin
      s = {stick_r, (d >= 2) ? ~axy_r : axy_r, (d % 2) == 1};
      dir_en[d] = stick_ok && en_r[s];
    end
  end

  assign stat.dir_en   = dir_en;
  assign stat.in_range = in_range;
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r    <= sddq_pkg::DZ_RESET;
      en_r    <= sddq_pkg::EN_RESET;
      flags_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sddq_pkg::REG_DEADZONE:   dz_r <= cfg_wdata[sddq_pkg::DZ_W-1:0];
          sddq_pkg::REG_DIR_ENABLE: en_r <= cfg_wdata[sddq_pkg::EN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        flags_r[slot] <= in_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      stick_r <= in_data.stick;
      axy_r   <= in_data.axis_is_y;
      pos_r   <= in_data.position;
      oth_r   <= in_data.other_position;
    end
    if (cmd.mul_en) begin
      prod_r <= sddq_pkg::SQ_W'(mul_op) * sddq_pkg::SQ_W'(mul_op);
    end
    if (cmd.acc_load) begin
      acc_r <= prod_r;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.dz2_load) begin
      dz2_r <= prod_r << 1;
    end
    // restoring divide, quotient limited to MAG_W bits
    if (cmd.div_init) begin
      rem_r <= num;
      dsh_r <= sddq_pkg::NUM_W'({divisor, (sddq_pkg::MAG_W - 1)'(0)});
      q_r   <= '0;
      sat_r <= (num >= div_full);
    end else if (cmd.div_step) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[sddq_pkg::MAG_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[sddq_pkg::MAG_W-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.out_load) begin
      out_r.direction_slot <= slot;
      out_r.changed        <= (in_range != flags_r[slot]);
      out_r.magnitude      <= mag;
      out_r.last           <= cmd.last;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sddq_ctrl.sv
// Controller: sequences squares, per-direction divide and result handshake.
`default_nettype none
module sddq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sddq_pkg::dp_stat_t stat,
  output sddq_pkg::dp_cmd_t      cmd
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SQ_POS   = 9'b000000010,
    ST_SQ_OTH   = 9'b000000100,
    ST_SQ_DZ    = 9'b000001000,
    ST_SQ_END   = 9'b000010000,
    ST_DIR_SEL  = 9'b000100000,
    ST_DIV_RUN  = 9'b001000000,
    ST_OUT_LOAD = 9'b010000000,
    ST_EMIT     = 9'b100000000
  } state_t;

  state_t                       state_r;
  state_t                       state_nxt;
  logic [sddq_pkg::DIR_W-1:0]   dir_r;
  logic [sddq_pkg::DIR_W-1:0]   dir_nxt;
  logic [sddq_pkg::CNT_W-1:0]   cnt_r;
  logic [sddq_pkg::CNT_W-1:0]   cnt_nxt;
  logic [sddq_pkg::NUM_DIRS-1:0] later;
  logic                         is_last;

  always_comb begin
    for (int k = 0; k < sddq_pkg::NUM_DIRS; k++) begin
      later[k] = (sddq_pkg::DIR_W'(k) > dir_r);
    end
  end

  assign is_last = ((stat.dir_en & later) == '0);

  always_comb begin
    state_nxt    = state_r;
    dir_nxt      = dir_r;
    cnt_nxt      = cnt_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    cmd.mul_sel  = sddq_pkg::MUL_POS;
    cmd.dir      = dir_r;
    cmd.last     = is_last;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          dir_nxt     = '0;
          state_nxt   = ST_SQ_POS;
        end
      end
      ST_SQ_POS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = sddq_pkg::MUL_POS;
        state_nxt   = ST_SQ_OTH;
      end
      ST_SQ_OTH: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = sddq_pkg::MUL_OTH;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_SQ_DZ;
      end
      ST_SQ_DZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = sddq_pkg::MUL_DZ;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_SQ_END;
      end
      ST_SQ_END: begin
        cmd.dz2_load = 1'b1;
        state_nxt    = ST_DIR_SEL;
      end
      ST_DIR_SEL: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        if (!stat.dir_en[dir_r]) begin
          if (dir_r == sddq_pkg::DIR_W'(sddq_pkg::NUM_DIRS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            dir_nxt = dir_r + sddq_pkg::DIR_W'(1);
          end
        end else if (stat.in_range) begin
          state_nxt = ST_DIV_RUN;
        end else begin
          state_nxt = ST_OUT_LOAD;
        end
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + sddq_pkg::CNT_W'(1);
        if (cnt_r == sddq_pkg::CNT_W'(sddq_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_OUT_LOAD;
        end
      end
      ST_OUT_LOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            dir_nxt   = dir_r + sddq_pkg::DIR_W'(1);
            state_nxt = ST_DIR_SEL;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dir_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dir_r   <= dir_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/stick_deadzone_direction_qualifier_unit.sv
// Per item: the three shared squarings, then each direction in turn: a disabled direction is
// skipped, an enabled one out of range goes straight to the result register, and one in range
// first runs the 8-step serial divider; each result beat then waits for out_ready.
// At most two directions are in range; an item with no direction enabled gives no result beat.
// One item at a time: a new input beat is taken only once the last item is done.
// Synchronous active-low reset: idle, status flags cleared, deadzone 8000, all directions on.
`default_nettype none
module stick_deadzone_direction_qualifier_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire sddq_pkg::in_beat_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output sddq_pkg::out_beat_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [sddq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sddq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sddq_pkg::dp_cmd_t  cmd;
  sddq_pkg::dp_stat_t stat;

  sddq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sddq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> tb/tb_stick_deadzone_direction_qualifier_unit.sv
// Self-checking testbench for stick_deadzone_direction_qualifier_unit with a built-in predictor.
`timescale 1ns / 1ps
module tb_stick_deadzone_direction_qualifier_unit;

  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 37;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  sddq_pkg::in_beat_t             in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  sddq_pkg::out_beat_t            out_data;
  logic                           cfg_we    = 1'b0;
  logic [sddq_pkg::CFG_IDX_W-1:0]  cfg_index = sddq_pkg::REG_DEADZONE;
  logic [sddq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  stick_deadzone_direction_qualifier_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  int unsigned dz_shadow = 8000;
  logic [7:0]  en_shadow = 8'hFF;
  bit          range_flag [8];

  sddq_pkg::in_beat_t  pending_events[$];
  sddq_pkg::out_beat_t predicted_results[$];

  int  errors       = 0;
  int  event_beats  = 0;
  int  result_beats = 0;
  int  settings     = 0;
  int  hold_asks    = 0;
  int  hold_served  = 0;
  int  hold_left    = 0;
  int  send_gap     = 0;
  int  recv_gap     = 0;
  int  quiet        = 0;
  bit  idle_on      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void grade_direction(input int axis, input int other, input bit positive,
                                          output bit hit, output logic [7:0] mag);
    longint a, o, sum, dz2, diff, span, q;
    bit side_ok;
    a       = (axis < 0) ? -axis : axis;
    o       = (other < 0) ? -other : other;
    sum     = a * a + o * o;
    dz2     = 2 * longint'(dz_shadow) * longint'(dz_shadow);
    side_ok = positive ? (axis > 0) : (axis < 0);
    hit     = 1'b0;
    mag     = '0;
    if (!side_ok || a < o / 2 || sum < dz2) return;
    hit  = 1'b1;
    diff = (a > dz_shadow) ? a - dz_shadow : 0;
    span = 32767 - longint'(dz_shadow);
    if (span == 0) begin
      mag = 8'd255;
      return;
    end
    q   = 1 + (diff * 254) / span;
    mag = (q > 255) ? 8'd255 : 8'(q);
  endfunction

  function automatic void predict_event(input sddq_pkg::in_beat_t ev);
    int                  pos, oth, n;
    logic                ax;
    logic [2:0]          slot;
    bit                  hit;
    logic [7:0]          mag;
    sddq_pkg::out_beat_t row [4];
    pos = int'($signed(ev.position));
    oth = int'($signed(ev.other_position));
    n   = 0;
    if (int'(ev.stick) >= sddq_pkg::NUM_STICKS) return;
    for (int d = 0; d < sddq_pkg::NUM_DIRS; d++) begin
      ax   = (d >= 2) ? ~ev.axis_is_y : ev.axis_is_y;
      slot = {ev.stick, ax, d[0]};
      if (!en_shadow[slot]) continue;
      if (d >= 2) grade_direction(oth, pos, d[0], hit, mag);
      else        grade_direction(pos, oth, d[0], hit, mag);
      row[n].direction_slot = slot;
      row[n].changed        = (hit != range_flag[slot]);
      row[n].magnitude      = mag;
      row[n].last           = 1'b0;
      range_flag[slot]      = hit;
      n++;
    end
    if (n > 0) row[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) predicted_results.insert(predicted_results.size(), row[i]);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_event(in_data);
        event_beats++;
      end
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_events.pop_front();
          send_gap = idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    sddq_pkg::out_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        result_beats++;
        if (predicted_results.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data.direction_slot !== want.direction_slot) begin
            $error("direction_slot: expected %0d, got %0d", want.direction_slot,
                   out_data.direction_slot);
            errors++;
          end
          if (out_data.changed !== want.changed) begin
            $error("changed: expected %0d, got %0d", want.changed, out_data.changed);
            errors++;
          end
          if (out_data.magnitude !== want.magnitude) begin
            $error("magnitude: expected %0d, got %0d", want.magnitude, out_data.magnitude);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            errors++;
          end
        end
        recv_gap = idle_on ? pick_gap() : 0;
      end
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: %0d results still expected", predicted_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [sddq_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= sddq_pkg::CFG_DATA_W'(val);
    if (idx == sddq_pkg::REG_DEADZONE) dz_shadow = val & 32'h7FFF;
    else                               en_shadow = val[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void add_event(input logic stick, input logic axis_y,
                                    input int pos, input int oth);
    sddq_pkg::in_beat_t ev;
    ev.stick          = stick;
    ev.axis_is_y      = axis_y;
    ev.position       = 16'(pos);
    ev.other_position = 16'(oth);
    pending_events.insert(pending_events.size(), ev);
  endfunction

  function automatic logic [15:0] near_radius(input int center);
    int m;
    m = center + int'($urandom_range(0, 3000)) - 1500;
    if (m < 0) m = 0;
    if (m > 32767) m = 32767;
    return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
  endfunction

  function automatic logic [15:0] extreme_value();
    case ($urandom_range(0, 6))
      0: return 16'sd0;
      1: return 16'sd1;
      2: return -16'sd1;
      3: return 16'sd32767;
      4: return 16'h8000;
      5: return 16'sd16384;
      default: return -16'sd16384;
    endcase
  endfunction

  function automatic sddq_pkg::in_beat_t random_event();
    sddq_pkg::in_beat_t ev;
    int mode;
    ev.stick     = 1'($urandom);
    ev.axis_is_y = 1'($urandom);
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      ev.position       = 16'($urandom);
      ev.other_position = 16'($urandom);
    end else if (mode < 7) begin
      ev.position       = near_radius(int'(dz_shadow));
      ev.other_position = near_radius(int'(dz_shadow));
    end else if (mode < 9) begin
      ev.position       = extreme_value();
      ev.other_position = extreme_value();
    end else begin
      ev.position       = 16'($urandom);
      ev.other_position = '0;
    end
    return ev;
  endfunction

  initial begin
    sddq_pkg::in_beat_t ev;
    int                 counted;
    int unsigned        dz_pick;
    logic [7:0]         en_pick;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings
    add_event(0, 0, 32767, 0);
    add_event(0, 0, -32768, -32768);
    add_event(0, 0, 0, 0);
    add_event(0, 1, 6000, 6000);
    add_event(0, 0, 5700, 11400);
    add_event(1, 1, -5700, -11400);
    add_event(1, 0, -1, 32767);
    add_event(1, 1, 32767, -32768);
    wait_drained();

    write_reg(sddq_pkg::REG_DEADZONE, 0);
    write_reg(sddq_pkg::REG_DIR_ENABLE, 8'hFF);
    settings++;
    @(negedge clk);
    add_event(0, 0, 0, 0);
    add_event(0, 0, 1, 2);
    add_event(0, 1, 1, 3);
    add_event(0, 0, 1, 4);
    add_event(1, 0, -32768, 1);
    wait_drained();

    // zero divisor
    write_reg(sddq_pkg::REG_DEADZONE, 32767);
    settings++;
    @(negedge clk);
    add_event(0, 0, 32767, 32767);
    add_event(1, 1, -32768, 32767);
    add_event(0, 1, 100, 100);
    wait_drained();

    // saturation
    write_reg(sddq_pkg::REG_DEADZONE, 32700);
    settings++;
    @(negedge clk);
    add_event(0, 0, -32768, -32768);
    add_event(1, 0, 32767, -20000);
    wait_drained();

    write_reg(sddq_pkg::REG_DEADZONE, 16000);
    write_reg(sddq_pkg::REG_DIR_ENABLE, 8'h00);
    settings++;
    @(negedge clk);
    add_event(0, 0, 30000, 0);
    wait_drained();

    write_reg(sddq_pkg::REG_DIR_ENABLE, 8'h5A);
    settings++;
    @(negedge clk);
    add_event(0, 0, 30000, -30000);
    add_event(1, 1, -30000, 30000);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: dz_pick = 0;
        1: dz_pick = 32767;
        2: dz_pick = $urandom_range(32500, 32767);
        3: dz_pick = $urandom_range(0, 2000);
        default: dz_pick = $urandom_range(0, 32767);
      endcase
      en_pick = ($urandom_range(0, 9) < 7) ? 8'hFF : 8'($urandom_range(1, 255));
      write_reg(sddq_pkg::REG_DEADZONE, dz_pick);
      write_reg(sddq_pkg::REG_DIR_ENABLE, en_pick);
      settings++;
      @(negedge clk);
      idle_on = (p != 0);
      if (p == 2) hold_asks++;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        ev = random_event();
        pending_events.insert(pending_events.size(), ev);
        if (en_shadow[{ev.stick, 2'b00} +: 4] != 4'h0) counted++;
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    $display("Checked %0d event beats and %0d result beats across %0d register settings,",
             event_beats, result_beats, settings);
    $display("including a long output hold-off and idle-to-idle drains between phases.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
